>>> hw/rtl/baro_pkg.sv
`timescale 1ns / 1ps
// Shared types for the barometer compensation block.
// Used by baro_cfg, baro_pipe and barometer_compensation; no dependencies.
package baro_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_coeff;
    logic [15:0] pressure_adjust;
    logic [31:0] curve_exponents;
  } cfg_t;

endpackage

>>> hw/rtl/baro_cfg.sv
`timescale 1ns / 1ps
// Calibration coefficient register file of the barometer compensation block.
// Depends on baro_pkg for the register bundle type.
module baro_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [baro_pkg::CfgIndexW-1:0]   wr_index,
  input  logic [baro_pkg::CfgDataW-1:0]    wr_data,
  output baro_pkg::cfg_t                   cfg
);
  import baro_pkg::*;

  localparam logic [CfgIndexW-1:0] RegSens    = 3'd0;
  localparam logic [CfgIndexW-1:0] RegOffset  = 3'd1;
  localparam logic [CfgIndexW-1:0] RegSensTc  = 3'd2;
  localparam logic [CfgIndexW-1:0] RegOffTc   = 3'd3;
  localparam logic [CfgIndexW-1:0] RegRefTemp = 3'd4;
  localparam logic [CfgIndexW-1:0] RegTempCo  = 3'd5;
  localparam logic [CfgIndexW-1:0] RegAdjust  = 3'd6;
  localparam logic [CfgIndexW-1:0] RegExps    = 3'd7;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        RegSens:    cfg_nxt.pressure_sensitivity   = wr_data[15:0];
        RegOffset:  cfg_nxt.pressure_offset        = wr_data[15:0];
        RegSensTc:  cfg_nxt.sensitivity_temp_coeff = wr_data[15:0];
        RegOffTc:   cfg_nxt.offset_temp_coeff      = wr_data[15:0];
        RegRefTemp: cfg_nxt.reference_temperature  = wr_data[15:0];
        RegTempCo:  cfg_nxt.temperature_coeff      = wr_data[15:0];
        RegAdjust:  cfg_nxt.pressure_adjust        = wr_data[15:0];
        RegExps:    cfg_nxt.curve_exponents        = wr_data;
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/baro_pipe.sv
`timescale 1ns / 1ps
// Nine-stage compensation datapath with per-stage valid bits and stall chain.
// Depends on baro_pkg for the calibration register bundle.
module baro_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  baro_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         raw_pressure,
  input  logic [15:0]         raw_temperature,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [17:0]  pressure_tenths,
  output logic signed [15:0]  temperature_tenths,
  output logic                reading_valid
);
  import baro_pkg::*;

  localparam int unsigned NStages = 9;

  logic [NStages:1]   v_r;
  logic [NStages+1:1] adv;

  always_comb begin
    adv[NStages+1] = out_ready;
    for (int k = NStages; k >= 1; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NStages; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = v_r[NStages];

  logic [7:0] gain_a, gain_b, curve_sh, temp_sh;
  assign gain_a   = cfg.curve_exponents[7:0];
  assign gain_b   = cfg.curve_exponents[15:8];
  assign curve_sh = cfg.curve_exponents[23:16];
  assign temp_sh  = cfg.curve_exponents[31:24];

  // Stage 1: temperature difference and pressure offset removal.
  logic signed [16:0] diff1_nxt, d1m1_nxt;
  logic signed [16:0] diff1_r, d1m1_r;
  logic               ge1_r, z1_r;
  assign diff1_nxt = $signed({1'b0, raw_temperature})
                   - $signed({1'b0, cfg.reference_temperature});
  assign d1m1_nxt  = $signed({1'b0, raw_pressure}) - 17'sd7168;

  // Stage 2: square of the difference.
  logic signed [33:0] sqp;
  logic [17:0]        sq2_r;
  logic signed [16:0] diff2_r, d1m2_r;
  logic               ge2_r, z2_r;
  assign sqp = 34'(diff1_r) * 34'(diff1_r);

  // Stage 3: gain of the second-order term.
  logic [25:0]        term3_nxt, term3_r;
  logic signed [16:0] diff3_r, d1m3_r;
  logic               z3_r;
  assign term3_nxt = 26'(sq2_r) * 26'(ge2_r ? gain_a : gain_b);

  // Stage 4: corrected temperature difference.
  logic [25:0]        corr;
  logic signed [27:0] dut4_nxt, dut4_r;
  logic signed [16:0] d1m4_r;
  logic               z4_r;
  assign corr     = term3_r >> curve_sh;
  assign dut4_nxt = 28'(diff3_r) - $signed({2'b00, corr});

  // Stage 5: coefficient products and temperature shift term.
  logic signed [16:0] offtc;
  logic signed [44:0] offp5_nxt, sensp5_nxt, tp5_nxt;
  logic signed [44:0] offp5_r, sensp5_r, tp5_r;
  logic signed [28:0] tsb;
  logic signed [28:0] tsq;
  logic signed [27:0] tsh5_nxt, tsh5_r;
  logic signed [16:0] d1m5_r;
  logic               z5_r;
  assign offtc      = $signed({1'b0, cfg.offset_temp_coeff}) - 17'sd1024;
  assign offp5_nxt  = 45'(offtc) * 45'(dut4_r);
  assign sensp5_nxt = 45'($signed({1'b0, cfg.sensitivity_temp_coeff})) * 45'(dut4_r);
  assign tp5_nxt    = 45'($signed({1'b0, cfg.temperature_coeff})) * 45'(dut4_r);
  always_comb begin
    tsb = 29'(dut4_r);
    if (dut4_r < 0) begin
      tsb = tsb + ((29'sd1 <<< temp_sh[4:0]) - 29'sd1);
    end
    tsq = tsb >>> temp_sh[4:0];
    if (temp_sh >= 8'd28) begin
      tsh5_nxt = '0;
    end else begin
      tsh5_nxt = tsq[27:0];
    end
  end

  // Stage 6: offset, sensitivity and temperature.
  logic signed [44:0] offb, sensb, tb;
  logic signed [30:0] offq;
  logic signed [34:0] sensq;
  logic signed [28:0] tq;
  logic signed [33:0] off6_nxt, off6_r;
  logic signed [34:0] sens6_nxt, sens6_r;
  logic signed [28:0] tval6_nxt, tval6_r;
  logic signed [16:0] d1m6_r;
  logic               z6_r;
  assign offb  = offp5_r + (offp5_r[44] ? 45'sd16383 : 45'sd0);
  assign offq  = offb[44:14];
  assign sensb = sensp5_r + (sensp5_r[44] ? 45'sd1023 : 45'sd0);
  assign sensq = sensb[44:10];
  assign tb    = tp5_r + (tp5_r[44] ? 45'sd65535 : 45'sd0);
  assign tq    = tb[44:16];
  assign off6_nxt  = (34'($signed({1'b0, cfg.pressure_offset})) + 34'(offq)) <<< 2;
  assign sens6_nxt = 35'($signed({1'b0, cfg.pressure_sensitivity})) + sensq;
  assign tval6_nxt = 29'sd250 + tq - 29'(tsh5_r);

  // Stage 7: sensitivity times pressure.
  logic signed [51:0] xp7_nxt, xp7_r;
  logic signed [33:0] off7_r;
  logic signed [28:0] tval7_r;
  logic               z7_r;
  assign xp7_nxt = 52'(sens6_r) * 52'(d1m6_r);

  // Stage 8: scaled pressure minus offset.
  logic signed [51:0] xb;
  logic signed [37:0] xq;
  logic signed [38:0] x8_nxt, x8_r;
  logic signed [28:0] tval8_r;
  logic               z8_r;
  assign xb     = xp7_r + (xp7_r[51] ? 52'sd16383 : 52'sd0);
  assign xq     = xb[51:14];
  assign x8_nxt = 39'(xq) - 39'(off7_r);

  // Stage 9: unit scaling, adjustment and saturation.
  logic signed [42:0] x10, x10b;
  logic signed [37:0] pq;
  logic signed [38:0] pfull;
  logic signed [17:0] p9_nxt, p9_r;
  logic signed [15:0] t9_nxt, t9_r;
  logic               ok9_r;
  assign x10   = (43'(x8_r) <<< 3) + (43'(x8_r) <<< 1);
  assign x10b  = x10 + (x10[42] ? 43'sd31 : 43'sd0);
  assign pq    = x10b[42:5];
  assign pfull = 39'(pq) + 39'($signed({1'b0, cfg.pressure_adjust}));
  always_comb begin
    if (z8_r) begin
      p9_nxt = '0;
    end else if (pfull < -39'sd131072) begin
      p9_nxt = -18'sd131072;
    end else if (pfull > 39'sd131071) begin
      p9_nxt = 18'sd131071;
    end else begin
      p9_nxt = pfull[17:0];
    end
    if (z8_r) begin
      t9_nxt = '0;
    end else if (tval8_r < -29'sd32768) begin
      t9_nxt = -16'sd32768;
    end else if (tval8_r > 29'sd32767) begin
      t9_nxt = 16'sd32767;
    end else begin
      t9_nxt = tval8_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      diff1_r <= diff1_nxt;
      d1m1_r  <= d1m1_nxt;
      ge1_r   <= !diff1_nxt[16];
      z1_r    <= (raw_pressure == 16'd0) || (raw_temperature == 16'd0);
    end
    if (adv[2]) begin
      sq2_r   <= sqp[31:14];
      diff2_r <= diff1_r;
      d1m2_r  <= d1m1_r;
      ge2_r   <= ge1_r;
      z2_r    <= z1_r;
    end
    if (adv[3]) begin
      term3_r <= term3_nxt;
      diff3_r <= diff2_r;
      d1m3_r  <= d1m2_r;
      z3_r    <= z2_r;
    end
    if (adv[4]) begin
      dut4_r <= dut4_nxt;
      d1m4_r <= d1m3_r;
      z4_r   <= z3_r;
    end
    if (adv[5]) begin
      offp5_r  <= offp5_nxt;
      sensp5_r <= sensp5_nxt;
      tp5_r    <= tp5_nxt;
      tsh5_r   <= tsh5_nxt;
      d1m5_r   <= d1m4_r;
      z5_r     <= z4_r;
    end
    if (adv[6]) begin
      off6_r  <= off6_nxt;
      sens6_r <= sens6_nxt;
      tval6_r <= tval6_nxt;
      d1m6_r  <= d1m5_r;
      z6_r    <= z5_r;
    end
    if (adv[7]) begin
      xp7_r   <= xp7_nxt;
      off7_r  <= off6_r;
      tval7_r <= tval6_r;
      z7_r    <= z6_r;
    end
    if (adv[8]) begin
      x8_r    <= x8_nxt;
      tval8_r <= tval7_r;
      z8_r    <= z7_r;
    end
    if (adv[9]) begin
      p9_r  <= p9_nxt;
      t9_r  <= t9_nxt;
      ok9_r <= !z8_r;
    end
  end

  assign pressure_tenths    = p9_r;
  assign temperature_tenths = t9_r;
  assign reading_valid      = ok9_r;

endmodule

>>> hw/rtl/barometer_compensation.sv
`timescale 1ns / 1ps
// Top level of the barometer compensation block.
// Depends on baro_pkg, baro_cfg and baro_pipe.
//
// Usage:
// The input stream carries one raw pressure and raw temperature pair per word.
// The output stream carries compensated pressure in tenths of hPa and
// temperature in tenths of a degree, with a flag in out_tuser that is low when
// either raw reading was zero; both result fields are then zero.
// Calibration coefficients are written through the cfg_ channel, one register
// per write, and are taken in every cycle (cfg_ready is always high). They
// must only be changed while no word is in flight.
// Each accepted word passes through the nine stage registers to out_tvalid. One
// word is accepted every cycle while out_tready is high or any stage is empty:
// a stage takes a new word whenever it is empty or its word moves on.
// Reset clears all stage valid bits and all coefficients to zero.
// When the receiver stalls, stages fill up behind the output register and
// in_tready falls only once every stage holds a word; nothing is lost.
module barometer_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // raw_pressure, raw_temperature
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,  // pressure_tenths, temperature_tenths
  output logic                            out_tuser,  // reading_valid
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [baro_pkg::CfgIndexW-1:0]  cfg_index,
  input  logic [baro_pkg::CfgDataW-1:0]   cfg_data
);
  import baro_pkg::*;

  cfg_t               cfg;
  logic signed [17:0] pressure_tenths;
  logic signed [15:0] temperature_tenths;
  logic               reading_valid;

  assign cfg_ready = 1'b1;

  baro_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  baro_pipe u_pipe (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .in_valid           (in_tvalid),
    .in_ready           (in_tready),
    .raw_pressure       (in_tdata[15:0]),
    .raw_temperature    (in_tdata[31:16]),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .pressure_tenths    (pressure_tenths),
    .temperature_tenths (temperature_tenths),
    .reading_valid      (reading_valid)
  );

  assign out_tdata = {6'd0, temperature_tenths, pressure_tenths};
  assign out_tuser = reading_valid;

endmodule
